/* design/scfp_pkg.sv */
`default_nettype none
package scfp_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0]  HDR_POS   = 8'hBB;
	localparam logic [7:0]  HDR_CLAW1 = 8'h01;
	localparam logic [7:0]  HDR_CLAW2 = 8'h02;
	localparam logic [7:0]  CLAW_ID   = 8'h03;
	localparam logic [7:0]  ID_MIN    = 8'h01;
	localparam logic [7:0]  ID_MAX    = 8'h04;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	localparam logic [2:0]  TGT_CLAW1 = 3'd4;
	localparam logic [2:0]  TGT_CLAW2 = 3'd5;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_ID,
		ST_D2,
		ST_D3,
		ST_D4,
		ST_D5,
		ST_CHK
	} pos_state_t;

	typedef enum logic [2:0] {
		TK_HEAD,
		TK_ID,
		TK_DATA,
		TK_DATA_LAST,
		TK_CHECK
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] data;
	} token_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/scfp_front.sv */
`default_nettype none
module scfp_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    accept,
	input  wire  [7:0]             rx_byte,
	output logic                   push,
	output scfp_pkg::token_t       token
);

	scfp_pkg::pos_state_t state_q;
	scfp_pkg::pos_state_t state_next;
	logic                 keep;

	always_comb begin
		state_next = state_q;
		case (state_q)
			scfp_pkg::ST_HUNT: begin
				if (rx_byte inside {scfp_pkg::HDR_POS, scfp_pkg::HDR_CLAW1,
					scfp_pkg::HDR_CLAW2}) begin
					state_next = scfp_pkg::ST_ID;
				end
			end
			scfp_pkg::ST_ID: begin
				if (rx_byte inside {[scfp_pkg::ID_MIN:scfp_pkg::ID_MAX]}) begin
					state_next = scfp_pkg::ST_D2;
				end else begin
					state_next = scfp_pkg::ST_HUNT;
				end
			end
			scfp_pkg::ST_D2:  state_next = scfp_pkg::ST_D3;
			scfp_pkg::ST_D3:  state_next = scfp_pkg::ST_D4;
			scfp_pkg::ST_D4:  state_next = scfp_pkg::ST_D5;
			scfp_pkg::ST_D5:  state_next = scfp_pkg::ST_CHK;
			scfp_pkg::ST_CHK: state_next = scfp_pkg::ST_HUNT;
			default:          state_next = scfp_pkg::ST_HUNT;
		endcase
	end

	always_comb begin
		keep       = 1'b1;
		token.kind = scfp_pkg::TK_DATA;
		token.data = rx_byte;
		case (state_q)
			scfp_pkg::ST_HUNT: begin
				token.kind = scfp_pkg::TK_HEAD;
				keep = rx_byte inside {scfp_pkg::HDR_POS, scfp_pkg::HDR_CLAW1,
					scfp_pkg::HDR_CLAW2};
			end
			scfp_pkg::ST_ID: begin
				token.kind = scfp_pkg::TK_ID;
				keep = rx_byte inside {[scfp_pkg::ID_MIN:scfp_pkg::ID_MAX]};
			end
			scfp_pkg::ST_D2, scfp_pkg::ST_D3, scfp_pkg::ST_D4: begin
				token.kind = scfp_pkg::TK_DATA;
			end
			scfp_pkg::ST_D5:  token.kind = scfp_pkg::TK_DATA_LAST;
			scfp_pkg::ST_CHK: token.kind = scfp_pkg::TK_CHECK;
			default:          keep = 1'b0;
		endcase
	end

	assign push = accept & keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scfp_pkg::ST_HUNT;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

endmodule
`default_nettype wire

/* design/scfp_fifo.sv */
`default_nettype none
module scfp_fifo #(
	parameter int unsigned WIDTH = 11,
	parameter int unsigned DEPTH = 2
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  wire  [WIDTH-1:0]          din,
	input  wire                       pop,
	output logic [WIDTH-1:0]          dout,
	output scfp_pkg::queue_status_t   status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push & ~status.full;
	assign do_pop       = pop & ~status.empty;
	assign dout         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/scfp_back.sv */
`default_nettype none
module scfp_back (
	input  wire                       clk,
	input  wire                       arst_n,
	input  scfp_pkg::queue_status_t   q_status,
	input  scfp_pkg::token_t          token,
	output logic                      pop,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [2:0]                target,
	output logic signed [31:0]        payload
);

	logic [7:0]  header_q;
	logic [7:0]  id_q;
	logic [31:0] shift_q;
	logic [7:0]  sum_q;
	logic [15:0] crc_q;
	logic        valid_q;
	logic [2:0]  target_q;
	logic [31:0] payload_q;

	logic [7:0]  sum_in;
	logic [15:0] crc_in;
	logic [7:0]  id_less;
	logic        hit;
	logic [2:0]  res_target;
	logic [31:0] res_payload;

	assign pop = ~q_status.empty & (~valid_q | out_ready);

	assign sum_in  = sum_q + token.data;
	assign crc_in  = scfp_pkg::crc_byte((token.kind == scfp_pkg::TK_HEAD) ?
		scfp_pkg::CRC_INIT : crc_q, token.data);
	assign id_less = id_q - 8'd1;

	always_comb begin
		hit         = 1'b0;
		res_target  = id_less[2:0];
		res_payload = shift_q;
		if (header_q == scfp_pkg::HDR_POS) begin
			hit = (token.data == sum_q);
		end else if (id_q == scfp_pkg::CLAW_ID) begin
			hit = (shift_q[31:24] == crc_q[7:0]) && (token.data == crc_q[15:8]);
			res_target  = (header_q == scfp_pkg::HDR_CLAW1) ? scfp_pkg::TGT_CLAW1 :
				scfp_pkg::TGT_CLAW2;
			res_payload = {24'h000000, shift_q[23:16]};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			case (token.kind)
				scfp_pkg::TK_HEAD: header_q <= token.data;
				scfp_pkg::TK_ID:   id_q     <= token.data;
				scfp_pkg::TK_DATA, scfp_pkg::TK_DATA_LAST: begin
					shift_q <= {token.data, shift_q[31:8]};
				end
				scfp_pkg::TK_CHECK: begin
					target_q  <= res_target;
					payload_q <= res_payload;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			crc_q   <= scfp_pkg::CRC_INIT;
			valid_q <= 1'b0;
		end else begin
			if (pop && (token.kind == scfp_pkg::TK_CHECK) && hit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				case (token.kind)
					scfp_pkg::TK_HEAD: begin
						sum_q <= token.data;
						crc_q <= crc_in;
					end
					scfp_pkg::TK_ID, scfp_pkg::TK_DATA: begin
						sum_q <= sum_in;
						crc_q <= crc_in;
					end
					scfp_pkg::TK_DATA_LAST: sum_q <= sum_in;
					default: ;
				endcase
			end
		end
	end

	assign out_valid = valid_q;
	assign target    = target_q;
	assign payload   = payload_q;

endmodule
`default_nettype wire

/* design/serial_command_frame_parser.sv */
// Serial command frame parser.
// The slave stream takes one received serial byte per beat on s_tdata. Bytes
// are gathered into seven-byte frames (header, id, four data bytes, check).
// Position frames (header 0xBB) are checked by an 8-bit sum; claw frames
// (header 0x01 or 0x02, id 3) by CRC-16/Modbus. A good frame gives one beat
// on the master stream: target in m_tdata[2:0], signed payload in
// m_tdata[34:3]; bad frames and stray bytes give nothing.
// A byte is taken every cycle while the queue is not full. The front classifies
// each byte by its place in the frame and puts frame bytes in a small queue; the
// back folds them into the running sum and CRC, one byte-wide CRC step per cycle
// unless the output stalls. m_tvalid is set in a register by a passing check byte.
// When the master side stalls, the result is held in the output register, the
// back stops draining the queue, and s_tready falls once the queue is full.
// Reset clears the frame position to header hunting, the sum to zero, the
// CRC to 0xFFFF, empties the queue and drops any pending result.
`default_nettype none
module serial_command_frame_parser #(
	parameter int unsigned QUEUE_DEPTH = scfp_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata    // [2:0] target, [34:3] payload, [39:35] zero
);

	logic                    accept;
	logic                    push;
	logic                    pop;
	scfp_pkg::token_t        tok_in;
	scfp_pkg::token_t        tok_out;
	logic [$bits(scfp_pkg::token_t)-1:0] tok_raw;
	scfp_pkg::queue_status_t q_status;
	logic [2:0]              target;
	logic signed [31:0]      payload;

	assign s_tready = ~q_status.full;
	assign accept   = s_tvalid & s_tready;

	scfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (s_tdata),
		.push    (push),
		.token   (tok_in)
	);

	scfp_fifo #(
		.WIDTH ($bits(scfp_pkg::token_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (tok_in),
		.pop    (pop),
		.dout   (tok_raw),
		.status (q_status)
	);

	assign tok_out = scfp_pkg::token_t'(tok_raw);

	scfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.token     (tok_out),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.target    (target),
		.payload   (payload)
	);

	assign m_tdata = {5'b00000, payload, target};

endmodule
`default_nettype wire
